>>> src/msf_pkg.sv
// ----------------------------------------------------------------------------
// msf_pkg
// Shared widths and defaults for the minimum spanning forest block.
// ----------------------------------------------------------------------------
package msf_pkg;

  localparam int NODE_W         = 6;
  localparam int WEIGHT_W       = 32;
  localparam int NODE_COUNT_W   = 7;
  localparam int MAX_NODES_DEF  = 64;
  localparam int MAX_EDGES_DEF  = 256;
  localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RST = 7'd64;

  typedef logic [NODE_W-1:0]   node_t;
  typedef logic [WEIGHT_W-1:0] weight_t;

endpackage

>>> src/minimum_spanning_forest.sv
// ----------------------------------------------------------------------------
// minimum_spanning_forest
// Kruskal minimum spanning forest over a loaded edge list, union-find in RAM.
// ----------------------------------------------------------------------------
// Load: one edge word per cycle, written straight into the edge RAM unless
//   it is dropped for a node out of range or a full RAM.
// Run (after the word with last set): re-seed the parent RAM, then for each
//   edge in key order a full minimum-key scan of the edge RAM plus two root
//   walks with path compression in the parent RAM.
// Input is held off for the whole run. Synchronous active-low reset clears
//   the edge count, drop flag and control; RAM contents are not cleared.
module minimum_spanning_forest #(
  parameter int MAX_NODES = msf_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES = msf_pkg::MAX_EDGES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [msf_pkg::NODE_COUNT_W-1:0]     cfg_node_count,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  msf_pkg::node_t                       in_node_a,
  input  msf_pkg::node_t                       in_node_b,
  input  msf_pkg::weight_t                     in_weight,
  input  logic                                 in_last,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output msf_pkg::node_t                       out_edge_a,
  output msf_pkg::node_t                       out_edge_b,
  output msf_pkg::weight_t                     out_edge_weight,
  output logic                                 out_last_edge,
  output logic                                 out_empty_res,
  output logic                                 out_dropped
);
  import msf_pkg::*;

  localparam int NW   = $clog2(MAX_NODES);
  localparam int EW   = $clog2(MAX_EDGES);
  localparam int CW   = (NW + 1 > NODE_COUNT_W) ? NW + 1 : NODE_COUNT_W;
  localparam int ED_W = 2 * NODE_W + WEIGHT_W;
  localparam int KW   = WEIGHT_W + EW;

  typedef enum logic [3:0] {
    S_LOAD, S_INIT, S_SCAN, S_WALK_W, S_WALK_C, S_COMP_W, S_COMP_C,
    S_UNION, S_EMIT, S_FINISH
  } state_t;

  state_t state_r;

  logic [NODE_COUNT_W-1:0] node_count_r;
  logic [EW:0]             total_r;
  logic                    drop_r;
  logic [NW-1:0]           init_r;

  // scan of the edge RAM
  logic [EW:0]   scan_r;
  logic          rd_v_r;
  logic [EW-1:0] rd_idx_r;
  logic          best_v_r;
  logic [KW-1:0] best_key_r;
  logic          prev_v_r;
  logic [KW-1:0] prev_key_r;
  node_t         best_a_r, best_b_r;
  weight_t       best_w_r;

  // union-find walk
  logic [NW-1:0] pa_r, start_r, root_r, ra_r;
  logic          phase_r;

  // held tree edge awaiting its successor (decides last_edge)
  logic          pend_v_r;
  node_t         pend_a_r, pend_b_r;
  weight_t       pend_w_r;

  logic          out_valid_r, out_last_r, out_empty_r, out_drop_r;
  node_t         out_a_r, out_b_r;
  weight_t       out_w_r;

  // effective node limit and drop check
  logic [CW-1:0] node_lim;
  logic          in_acc, in_drop;
  always_comb begin
    if (CW'(node_count_r) > CW'(MAX_NODES)) node_lim = CW'(MAX_NODES);
    else                                     node_lim = CW'(node_count_r);
  end
  assign in_ready = (state_r == S_LOAD);
  assign in_acc   = in_valid && in_ready;
  assign in_drop  = (CW'(in_node_a) >= node_lim) || (CW'(in_node_b) >= node_lim) ||
                    (total_r == (EW+1)'(MAX_EDGES));

  // edge RAM
  logic [ED_W-1:0] ed_rd;
  node_t           rd_a, rd_b;
  weight_t         rd_w;
  logic [KW-1:0]   rd_key;
  logic            rd_better;
  msf_ram #(.DATA_W(ED_W), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk     (clk),
    .wr_en   (in_acc && !in_drop),
    .wr_addr (total_r[EW-1:0]),
    .wr_data ({in_node_a, in_node_b, in_weight}),
    .rd_addr (scan_r[EW-1:0]),
    .rd_data (ed_rd)
  );
  assign {rd_a, rd_b, rd_w} = ed_rd;
  // sign bit flipped so an unsigned compare orders signed weights; index breaks ties
  assign rd_key    = {~rd_w[WEIGHT_W-1], rd_w[WEIGHT_W-2:0], rd_idx_r};
  assign rd_better = (!prev_v_r || rd_key > prev_key_r) &&
                     (!best_v_r || rd_key < best_key_r);

  // parent RAM
  logic          pw_en;
  logic [NW-1:0] pw_addr, pw_data, p_rd;
  always_comb begin
    pw_en   = 1'b0;
    pw_addr = init_r;
    pw_data = init_r;
    unique case (state_r)
      S_INIT:   pw_en = 1'b1;
      S_COMP_C: begin
        pw_en   = (p_rd != root_r);
        pw_addr = pa_r;
        pw_data = root_r;
      end
      S_UNION:  begin
        pw_en   = (ra_r != root_r);
        pw_addr = ra_r;
        pw_data = root_r;
      end
      default:  pw_en = 1'b0;
    endcase
  end
  msf_ram #(.DATA_W(NW), .DEPTH(MAX_NODES)) u_parent_ram (
    .clk     (clk),
    .wr_en   (pw_en),
    .wr_addr (pw_addr),
    .wr_data (pw_data),
    .rd_addr (pa_r),
    .rd_data (p_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_LOAD;
      node_count_r <= NODE_COUNT_RST;
      total_r      <= '0;
      drop_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      pend_v_r     <= 1'b0;
      rd_v_r       <= 1'b0;
      best_v_r     <= 1'b0;
      prev_v_r     <= 1'b0;
      phase_r      <= 1'b0;
      init_r       <= '0;
      scan_r       <= '0;
    end else begin
      if (cfg_we) node_count_r <= cfg_node_count;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      rd_v_r <= 1'b0;

      unique case (state_r)
        S_LOAD: begin
          if (in_acc) begin
            if (in_drop) drop_r  <= 1'b1;
            else         total_r <= total_r + 1'b1;
            if (in_last) begin
              init_r   <= '0;
              prev_v_r <= 1'b0;
              pend_v_r <= 1'b0;
              state_r  <= S_INIT;
            end
          end
        end
        // seed every node as its own root
        S_INIT: begin
          init_r <= init_r + 1'b1;
          if (init_r == NW'(MAX_NODES - 1)) begin
            scan_r   <= '0;
            best_v_r <= 1'b0;
            state_r  <= S_SCAN;
          end
        end
        // find the smallest key above the previous one
        S_SCAN: begin
          if (rd_v_r && rd_better) begin
            best_v_r   <= 1'b1;
            best_key_r <= rd_key;
            best_a_r   <= rd_a;
            best_b_r   <= rd_b;
            best_w_r   <= rd_w;
          end
          if (scan_r < total_r) begin
            scan_r   <= scan_r + 1'b1;
            rd_v_r   <= 1'b1;
            rd_idx_r <= scan_r[EW-1:0];
          end else if (!rd_v_r) begin
            if (!best_v_r) begin
              state_r <= S_FINISH;
            end else begin
              prev_v_r   <= 1'b1;
              prev_key_r <= best_key_r;
              pa_r       <= NW'(best_a_r);
              start_r    <= NW'(best_a_r);
              phase_r    <= 1'b0;
              state_r    <= S_WALK_W;
            end
          end
        end
        S_WALK_W: state_r <= S_WALK_C;
        S_WALK_C: begin
          if (p_rd == pa_r) begin
            root_r  <= pa_r;
            pa_r    <= start_r;
            state_r <= S_COMP_W;
          end else begin
            pa_r    <= p_rd;
            state_r <= S_WALK_W;
          end
        end
        S_COMP_W: state_r <= S_COMP_C;
        // compress: point each node on the path straight at the root
        S_COMP_C: begin
          if (p_rd == root_r) begin
            if (!phase_r) begin
              ra_r    <= root_r;
              phase_r <= 1'b1;
              pa_r    <= NW'(best_b_r);
              start_r <= NW'(best_b_r);
              state_r <= S_WALK_W;
            end else begin
              state_r <= S_UNION;
            end
          end else begin
            pa_r    <= p_rd;
            state_r <= S_COMP_W;
          end
        end
        S_UNION: begin
          scan_r   <= '0;
          best_v_r <= 1'b0;
          if (ra_r == root_r) begin
            state_r <= S_SCAN;
          end else if (pend_v_r) begin
            state_r <= S_EMIT;
          end else begin
            pend_v_r <= 1'b1;
            pend_a_r <= best_a_r;
            pend_b_r <= best_b_r;
            pend_w_r <= best_w_r;
            state_r  <= S_SCAN;
          end
        end
        // release the held edge, hold the new one
        S_EMIT: begin
          if (!out_valid_r) begin
            out_valid_r <= 1'b1;
            out_a_r     <= pend_a_r;
            out_b_r     <= pend_b_r;
            out_w_r     <= pend_w_r;
            out_last_r  <= 1'b0;
            out_empty_r <= 1'b0;
            out_drop_r  <= drop_r;
            pend_a_r    <= best_a_r;
            pend_b_r    <= best_b_r;
            pend_w_r    <= best_w_r;
            state_r     <= S_SCAN;
          end
        end
        S_FINISH: begin
          if (!out_valid_r) begin
            out_valid_r <= 1'b1;
            out_a_r     <= pend_v_r ? pend_a_r : '0;
            out_b_r     <= pend_v_r ? pend_b_r : '0;
            out_w_r     <= pend_v_r ? pend_w_r : '0;
            out_last_r  <= 1'b1;
            out_empty_r <= !pend_v_r;
            out_drop_r  <= drop_r;
            pend_v_r    <= 1'b0;
            total_r     <= '0;
            drop_r      <= 1'b0;
            state_r     <= S_LOAD;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_edge_a      = out_a_r;
  assign out_edge_b      = out_b_r;
  assign out_edge_weight = out_w_r;
  assign out_last_edge   = out_last_r;
  assign out_empty_res   = out_empty_r;
  assign out_dropped     = out_drop_r;

  a_total_cap: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= (EW+1)'(MAX_EDGES))
    else $error("edge count beyond capacity");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_empty_r |-> out_last_r)
    else $error("empty result without last flag");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LOAD |-> !pend_v_r)
    else $error("held edge left over after run");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT || state_r == S_FINISH) && !out_valid_r |=> out_valid_r)
    else $error("result not issued from free slot");

endmodule

>>> src/msf_ram.sv
// ----------------------------------------------------------------------------
// msf_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module msf_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
